### rtl/core/pli_pkg.sv
// Shared types and constants for the piecewise linear interpolator.
package pli_pkg;

  localparam int MaxPointsDef = 64;

  localparam int DataW = 32;
  localparam int OpW   = DataW + 1;
  localparam int ProdW = 2 * OpW;
  localparam int QuoW  = 35;
  localparam logic [QuoW-1:0] QuoMax = QuoW'(64'd1 << 34);

  localparam logic [1:0] KIND_CLEAR = 2'd0;
  localparam logic [1:0] KIND_LOAD  = 2'd1;
  localparam logic [1:0] KIND_QUERY = 2'd2;

  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_EXTR = 2'd1;
  localparam logic [1:0] STAT_FEW  = 2'd2;
  localparam logic [1:0] STAT_ZERO = 2'd3;

  typedef struct packed {
    logic                    valid;
    logic                    found;
    logic                    below;
    logic signed [DataW-1:0] x;
    logic signed [DataW-1:0] x1;
    logic signed [DataW-1:0] y1;
    logic signed [DataW-1:0] x2;
    logic signed [DataW-1:0] y2;
  } pli_tok_t;

endpackage

### rtl/core/pli_in_if.sv
// Input channel: clear, load and query items.
interface pli_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;

  modport source (output valid, kind, point_x, point_y, input ready);
  modport sink   (input valid, kind, point_x, point_y, output ready);
endinterface

### rtl/core/pli_out_if.sv
// Output channel: interpolated value and status.
interface pli_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] value_y;
  logic [1:0]         status;

  modport source (output valid, value_y, status, input ready);
  modport sink   (input valid, value_y, status, output ready);
endinterface

### rtl/core/pli_cell.sv
// One breakpoint cell: stores a point and tests the passing query against its segment.
module pli_cell import pli_pkg::*; #(
  parameter int MAX_POINTS = MaxPointsDef,
  parameter int I          = 0,
  localparam int CW        = $clog2(MAX_POINTS + 1)
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    load_en_i,
  input  logic signed [DataW-1:0] load_x_i,
  input  logic signed [DataW-1:0] load_y_i,
  input  logic [CW-1:0]           count_i,
  input  logic signed [DataW-1:0] next_x_i,
  input  logic signed [DataW-1:0] next_y_i,
  input  pli_tok_t                tok_i,
  output pli_tok_t                tok_o,
  output logic signed [DataW-1:0] x_o,
  output logic signed [DataW-1:0] y_o
);

  logic signed [DataW-1:0] x_q, y_q;
  pli_tok_t tok_q, tok_d;
  logic seg_ok, last, below, hit, take;

  always_ff @(posedge clk_i) begin
    if (load_en_i && ({1'b0, count_i} == (CW+1)'(I))) begin
      x_q <= load_x_i;
      y_q <= load_y_i;
    end
  end

  always_comb begin
    seg_ok = {1'b0, count_i} > (CW+1)'(I + 1);
    last   = {1'b0, count_i} == (CW+1)'(I + 2);
    below  = (I == 0) ? (tok_i.x < x_q) : tok_i.below;
    hit    = tok_i.valid && !tok_i.found && seg_ok && (x_q <= tok_i.x) && (tok_i.x < next_x_i);
    take   = hit || (tok_i.valid && !tok_i.found &&
                     (((I == 0) && below) || (last && !below)));
    tok_d       = tok_i;
    tok_d.below = below;
    if (take) begin
      tok_d.x1 = x_q;
      tok_d.y1 = y_q;
      tok_d.x2 = next_x_i;
      tok_d.y2 = next_y_i;
    end
    if (hit) begin
      tok_d.found = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  assign tok_o = tok_q;
  assign x_o   = x_q;
  assign y_o   = y_q;

endmodule

### rtl/core/pli_muldiv.sv
// Serial shift-add multiply then restoring divide, one bit per cycle.
module pli_muldiv import pli_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [OpW-1:0]   a_i,
  input  logic [OpW-1:0]   b_i,
  input  logic [OpW-1:0]   d_i,
  output logic             done_o,
  output logic [QuoW-1:0]  q_o
);

  localparam int CntW = $clog2(ProdW + 1);

  typedef enum logic [1:0] {ST_IDLE, ST_MUL, ST_DIV} state_e;

  state_e           state_q;
  logic [CntW-1:0]  cnt_q;
  logic [ProdW-1:0] p_q;
  logic [OpW-1:0]   a_q, d_q;
  logic [OpW+1:0]   r_q;
  logic             done_q;
  logic [OpW:0]     upper;
  logic [OpW+1:0]   r_sh;
  logic             ge;

  always_comb begin
    upper = {1'b0, p_q[ProdW-1:OpW]} + (p_q[0] ? {1'b0, a_q} : '0);
    r_sh  = {r_q[OpW:0], p_q[ProdW-1]};
    ge    = r_sh >= {2'b00, d_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (start_i) begin
            a_q     <= a_i;
            d_q     <= d_i;
            p_q     <= {{OpW{1'b0}}, b_i};
            cnt_q   <= '0;
            state_q <= ST_MUL;
          end
        end
        ST_MUL: begin
          p_q <= {upper, p_q[OpW-1:1]};
          if (cnt_q == CntW'(OpW - 1)) begin
            cnt_q   <= '0;
            r_q     <= '0;
            state_q <= ST_DIV;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        ST_DIV: begin
          r_q <= ge ? r_sh - {2'b00, d_q} : r_sh;
          p_q <= {p_q[ProdW-2:0], ge};
          if (cnt_q == CntW'(ProdW - 1)) begin
            done_q  <= 1'b1;
            state_q <= ST_IDLE;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign done_o = done_q;
  assign q_o    = (p_q > ProdW'(QuoMax)) ? QuoMax : p_q[QuoW-1:0];

endmodule

### rtl/core/piecewise_linear_interpolator.sv
// Top level: breakpoint cell chain, serial multiply-divide and result register.
//   channel | dir | transfer when   | payload
//   in_i    | in  | valid & ready   | kind, point_x, point_y
//   out_o   | out | valid & ready   | value_y, status
// Clear and load complete directly from idle. A query passes through the cell chain,
// starts the serial multiply-divide, waits for it and then finishes into the output
// register. A zero-width segment skips the divide, and a table with fewer than two points
// answers without a search.
// Reset empties the table and the output register; stored points need no reset.
// A finished result waits in the output register while the next item is taken; a second
// result stalls until that register is free.
module piecewise_linear_interpolator import pli_pkg::*; #(
  parameter int MAX_POINTS = MaxPointsDef
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  pli_in_if.sink   in_i,
  pli_out_if.source out_o
);

  localparam int CW = $clog2(MAX_POINTS + 1);

  typedef enum logic [2:0] {ST_IDLE, ST_SEARCH, ST_CALC, ST_WAIT, ST_FINISH} state_e;

  state_e          state_q;
  logic [CW-1:0]   count_q;
  logic            acc, load_en;
  pli_tok_t        tok_in;
  pli_tok_t        tok  [MAX_POINTS];
  logic signed [DataW-1:0] cx [MAX_POINTS];
  logic signed [DataW-1:0] cy [MAX_POINTS];

  pli_tok_t        seg_q;
  logic            neg_q;
  logic signed [DataW-1:0] res_y_q;
  logic [1:0]      res_st_q;
  logic            out_valid_q;
  logic signed [DataW-1:0] out_y_q;
  logic [1:0]      out_st_q;

  logic signed [OpW-1:0] dx, dy, w;
  logic [OpW-1:0]  mdx, mdy, mw;
  logic            md_start, md_done;
  logic [QuoW-1:0] md_q;
  logic signed [QuoW+1:0] sum;

  assign acc     = in_i.valid && in_i.ready;
  assign load_en = acc && (in_i.kind == KIND_LOAD) && (count_q != CW'(MAX_POINTS));

  always_comb begin
    tok_in       = '0;
    tok_in.valid = acc && (in_i.kind == KIND_QUERY) && (count_q >= CW'(2));
    tok_in.x     = in_i.point_x;
  end

  for (genvar g = 0; g < MAX_POINTS; g++) begin : g_cell
    pli_cell #(.MAX_POINTS(MAX_POINTS), .I(g)) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .load_en_i (load_en),
      .load_x_i  (in_i.point_x),
      .load_y_i  (in_i.point_y),
      .count_i   (count_q),
      .next_x_i  ((g == MAX_POINTS - 1) ? '0 : cx[(g + 1) % MAX_POINTS]),
      .next_y_i  ((g == MAX_POINTS - 1) ? '0 : cy[(g + 1) % MAX_POINTS]),
      .tok_i     ((g == 0) ? tok_in : tok[(g + MAX_POINTS - 1) % MAX_POINTS]),
      .tok_o     (tok[g]),
      .x_o       (cx[g]),
      .y_o       (cy[g])
    );
  end

  always_comb begin
    dx  = {seg_q.x[DataW-1], seg_q.x} - {seg_q.x1[DataW-1], seg_q.x1};
    dy  = {seg_q.y2[DataW-1], seg_q.y2} - {seg_q.y1[DataW-1], seg_q.y1};
    w   = {seg_q.x2[DataW-1], seg_q.x2} - {seg_q.x1[DataW-1], seg_q.x1};
    mdx = dx[OpW-1] ? -dx : dx;
    mdy = dy[OpW-1] ? -dy : dy;
    mw  = w[OpW-1]  ? -w  : w;
    md_start = (state_q == ST_CALC) && (w != '0);
    sum = neg_q ? (QuoW+2)'(res_y_q) - (QuoW+2)'({1'b0, md_q})
                : (QuoW+2)'(res_y_q) + (QuoW+2)'({1'b0, md_q});
  end

  pli_muldiv u_muldiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (md_start),
    .a_i     (mdx),
    .b_i     (mdy),
    .d_i     (mw),
    .done_o  (md_done),
    .q_o     (md_q)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_o.ready && (state_q != ST_FINISH)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (acc) begin
            case (in_i.kind)
              KIND_CLEAR: count_q <= '0;
              KIND_LOAD: begin
                if (load_en) count_q <= count_q + 1'b1;
              end
              KIND_QUERY: begin
                if (count_q < CW'(2)) begin
                  res_y_q  <= '0;
                  res_st_q <= STAT_FEW;
                  state_q  <= ST_FINISH;
                end else begin
                  state_q <= ST_SEARCH;
                end
              end
              default: ;
            endcase
          end
        end
        ST_SEARCH: begin
          if (tok[MAX_POINTS-1].valid) begin
            seg_q   <= tok[MAX_POINTS-1];
            state_q <= ST_CALC;
          end
        end
        ST_CALC: begin
          res_y_q <= seg_q.y1;
          neg_q   <= (dx[OpW-1] != dy[OpW-1]) != w[OpW-1];
          if (w == '0) begin
            res_st_q <= STAT_ZERO;
            state_q  <= ST_FINISH;
          end else begin
            res_st_q <= seg_q.found ? STAT_OK : STAT_EXTR;
            state_q  <= ST_WAIT;
          end
        end
        ST_WAIT: begin
          if (md_done) begin
            if (sum > (QuoW+2)'(32'sh7FFF_FFFF)) begin
              res_y_q <= 32'sh7FFF_FFFF;
            end else if (sum < -(QuoW+2)'(33'sh0_8000_0000)) begin
              res_y_q <= 32'sh8000_0000;
            end else begin
              res_y_q <= sum[DataW-1:0];
            end
            state_q <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (!out_valid_q || out_o.ready) begin
            out_valid_q <= 1'b1;
            out_y_q     <= res_y_q;
            out_st_q    <= res_st_q;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_i.ready    = (state_q == ST_IDLE);
  assign out_o.valid   = out_valid_q;
  assign out_o.value_y = out_y_q;
  assign out_o.status  = out_st_q;

endmodule

### rtl/core/pli_checker.sv
// Port-level checks for the interpolator, bound to the top level.
module pli_checker import pli_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic [1:0]  kind_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [31:0] value_y_i,
  input logic [1:0]  status_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i) else $error("result dropped while stalled");

  a_few_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (status_i == STAT_FEW) |-> value_y_i == '0)
    else $error("short table gave nonzero");

  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && (kind_i == KIND_QUERY) |=> !in_ready_i)
    else $error("input open during query");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && (kind_i != KIND_QUERY) && !out_valid_i |=> !out_valid_i)
    else $error("result without query");

endmodule

bind piecewise_linear_interpolator pli_checker u_pli_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .kind_i      (in_i.kind),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .value_y_i   (out_o.value_y),
  .status_i    (out_o.status)
);

### test/pli_tb_if.sv
// Testbench note: the interfaces come from the RTL; this file holds shared test types.
package pli_tb_pkg;
  import pli_pkg::*;

  typedef struct {
    logic [1:0]         kind;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
  } pli_item_t;

  typedef struct {
    logic signed [31:0] value_y;
    logic [1:0]         status;
  } pli_result_t;
endpackage

### test/tb_top.sv
// Testbench top: drives directed and random tables and queries, checks results against a predictor.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import pli_pkg::*;
  import pli_tb_pkg::*;

  localparam int NPts = MaxPointsDef;
  localparam int WatchLimit = 20000;
  localparam int KindUnused = 3;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  pli_in_if  in_ch();
  pli_out_if out_ch();

  piecewise_linear_interpolator dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch.sink),
    .out_o (out_ch.source)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  pli_item_t   pending_items[$];
  pli_result_t expected_results[$];
  logic signed [31:0] bp_x[NPts];
  logic signed [31:0] bp_y[NPts];
  int unsigned bp_count = 0;
  int errors = 0;
  int send_idle_pct;
  int recv_stall_pct;
  int hold_off_cycles;
  int stall_count;
  bit sender_paused;
  int idle_cycles = 0;
  logic in_fire;

  function automatic logic [63:0] abs64(longint v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  function automatic pli_result_t interpolate(logic signed [31:0] qx);
    pli_result_t r;
    int seg;
    bit hit;
    longint x1, y1, x2, y2, w, dx, dy, res;
    logic [127:0] prod, quo;
    r.status = STAT_OK;
    hit = 0;
    seg = 0;
    if (bp_count < 2) begin
      r.value_y = '0;
      r.status = STAT_FEW;
      return r;
    end
    for (int i = 0; i + 1 < bp_count; i++) begin
      if (!hit && bp_x[i] <= qx && qx < bp_x[i+1]) begin
        seg = i;
        hit = 1;
      end
    end
    if (!hit) begin
      r.status = STAT_EXTR;
      seg = (qx < bp_x[0]) ? 0 : bp_count - 2;
    end
    x1 = bp_x[seg];
    y1 = bp_y[seg];
    x2 = bp_x[seg+1];
    y2 = bp_y[seg+1];
    w = x2 - x1;
    if (w == 0) begin
      r.value_y = y1[31:0];
      r.status = STAT_ZERO;
      return r;
    end
    dx = longint'(qx) - x1;
    dy = y2 - y1;
    prod = 128'(abs64(dx)) * 128'(abs64(dy));
    quo = prod / 128'(abs64(w));
    if (quo > (128'd1 << 34)) quo = 128'd1 << 34;
    if (((dx < 0) != (dy < 0)) != (w < 0)) res = y1 - longint'(quo[63:0]);
    else res = y1 + longint'(quo[63:0]);
    if (res > 64'sd2147483647) res = 64'sd2147483647;
    if (res < -64'sd2147483648) res = -64'sd2147483648;
    r.value_y = res[31:0];
    return r;
  endfunction

  function automatic void apply_item(pli_item_t it);
    case (it.kind)
      KIND_CLEAR: begin
        bp_count = 0;
      end
      KIND_LOAD: begin
        if (bp_count < NPts) begin
          bp_x[bp_count] = it.point_x;
          bp_y[bp_count] = it.point_y;
          bp_count++;
        end
      end
      KIND_QUERY: begin
        expected_results.insert(expected_results.size(), interpolate(it.point_x));
      end
      default: ;
    endcase
  endfunction

  function automatic logic signed [31:0] rand32();
    case ($urandom_range(0, 5))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return 32'($urandom_range(0, 8)) - 4;
      default: return $urandom;
    endcase
  endfunction

  task automatic push(logic [1:0] k, logic signed [31:0] x, logic signed [31:0] y);
    pli_item_t it;
    it.kind = k;
    it.point_x = x;
    it.point_y = y;
    pending_items.insert(pending_items.size(), it);
  endtask

  task automatic push_table(int n, bit sorted, bit wide);
    int step;
    logic signed [31:0] x;
    push(KIND_CLEAR, $urandom, $urandom);
    step = wide ? 32'h0100_0000 : $urandom_range(1, 32'h0002_0000);
    x = sorted ? -(32'(n) * step / 2) : 0;
    for (int i = 0; i < n; i++) begin
      if (sorted) x += step * 32'($urandom_range(0, 3) != 0) + $urandom_range(0, 255);
      else x = rand32();
      push(KIND_LOAD, x, rand32());
    end
  endtask

  task automatic wait_drain();
    while (pending_items.size() != 0 || in_ch.valid) @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  // input transfer seen at the last rising edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_fire <= 1'b0;
    end else begin
      in_fire <= in_ch.valid && in_ch.ready;
    end
  end

  // driver
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
      in_ch.kind <= KIND_CLEAR;
      in_ch.point_x <= '0;
      in_ch.point_y <= '0;
    end else if (!in_ch.valid || in_fire) begin
      if (pending_items.size() != 0 && !sender_paused &&
          $urandom_range(1, 100) > send_idle_pct) begin
        in_ch.valid <= 1'b1;
        in_ch.kind <= pending_items[0].kind;
        in_ch.point_x <= pending_items[0].point_x;
        in_ch.point_y <= pending_items[0].point_y;
        pending_items.pop_front();
      end else begin
        in_ch.valid <= 1'b0;
        in_ch.kind <= 2'($urandom);
        in_ch.point_x <= $urandom;
        in_ch.point_y <= $urandom;
      end
    end
  end

  // sink ready, with a long hold-off when requested
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
      stall_count <= 0;
    end else if (hold_off_cycles > 0 && stall_count < hold_off_cycles) begin
      out_ch.ready <= 1'b0;
      stall_count <= stall_count + 1;
    end else begin
      out_ch.ready <= ($urandom_range(1, 100) > recv_stall_pct);
      if (hold_off_cycles == 0) stall_count <= 0;
    end
  end

  // monitor
  always @(posedge clk_i) begin
    pli_item_t it;
    pli_result_t exp_r;
    bit active;
    if (rst_ni) begin
      active = 0;
      if (in_ch.valid && in_ch.ready) begin
        it.kind = in_ch.kind;
        it.point_x = in_ch.point_x;
        it.point_y = in_ch.point_y;
        apply_item(it);
        active = 1;
      end
      if (out_ch.valid && out_ch.ready) begin
        active = 1;
        if (expected_results.size() == 0) begin
          $error("unexpected result value_y=%h status=%0d", out_ch.value_y, out_ch.status);
          errors++;
        end else begin
          exp_r = expected_results.pop_front();
          if (out_ch.value_y !== exp_r.value_y) begin
            $error("value_y expected %h actual %h", exp_r.value_y, out_ch.value_y);
            errors++;
          end
          if (out_ch.status !== exp_r.status) begin
            $error("status expected %0d actual %0d", exp_r.status, out_ch.status);
            errors++;
          end
        end
      end
      idle_cycles <= active ? 0 : idle_cycles + 1;
      if (idle_cycles >= WatchLimit) begin
        $display("piecewise_linear_interpolator: mismatch");
        $finish;
      end
    end
  end

  initial begin
    int n;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_off_cycles = 0;
    sender_paused = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty and single-point tables, exact points, extremes, unused kind
    push(KIND_QUERY, 32'sh7fffffff, 0);
    push(KIND_LOAD, 32'sh80000000, 32'sh7fffffff);
    push(KIND_QUERY, 0, 0);
    push(KIND_LOAD, 32'sh7fffffff, 32'sh80000000);
    push(KIND_QUERY, 32'sh80000000, 0);
    push(KIND_QUERY, 32'sh7fffffff, 0);
    push(KIND_QUERY, 0, 32'shffffffff);
    push(KIND_QUERY, 32'sh40000000, 0);
    push(2'(KindUnused), 0, 0);
    push(KIND_CLEAR, 0, 0);
    push(KIND_LOAD, 32'h10000, 32'h10000);
    push(KIND_LOAD, 32'h10000, 32'h50000);
    push(KIND_LOAD, 32'h30000, 32'sh80000000);
    push(KIND_QUERY, 32'h8000, 0);
    push(KIND_QUERY, 32'h10000, 0);
    push(KIND_QUERY, 32'h20000, 0);
    push(KIND_QUERY, 32'h40000, 0);
    push(KIND_CLEAR, 0, 0);
    push(KIND_LOAD, 32'sh80000000, 32'sh80000000);
    push(KIND_LOAD, 32'sh80000001, 32'sh7fffffff);
    push(KIND_QUERY, 32'sh7fffffff, 0);
    push(KIND_QUERY, 32'sh80000000, 0);
    wait_drain();

    // full table plus overflowing loads; hold off receiver while sender keeps offering
    push_table(NPts + 3, 1, 0);
    for (int i = 0; i < 12; i++) push(KIND_QUERY, rand32(), 0);
    hold_off_cycles = 3000;
    wait_drain();
    hold_off_cycles = 0;

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = (ph == 1 || ph == 3) ? (ph == 1 ? 67 : 33) : 0;
      recv_stall_pct = (ph == 2 || ph == 3) ? (ph == 2 ? 67 : 33) : 0;
      for (int t = 0; t < 8; t++) begin
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 10);
        if ($urandom_range(0, 15) == 0) n = NPts;
        push_table(n, $urandom_range(0, 4) != 0, $urandom_range(0, 3) == 0);
        for (int q = 0; q < 8; q++) begin
          if ($urandom_range(0, 20) == 0) push(2'(KindUnused), $urandom, $urandom);
          else push(KIND_QUERY, rand32(), $urandom);
        end
      end
      if (ph == 0) begin
        // pause the sender halfway until every expected result has come
        n = pending_items.size() / 2;
        while (pending_items.size() > n) @(posedge clk_i);
        sender_paused = 1;
        while (in_ch.valid || expected_results.size() != 0) @(posedge clk_i);
        sender_paused = 0;
      end
      wait_drain();
    end

    repeat (400) @(posedge clk_i);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("piecewise_linear_interpolator: match");
    end else begin
      $display("piecewise_linear_interpolator: mismatch");
    end
    $finish;
  end
endmodule
